// ===== sv/minimum_spanning_tree_engine_macros.svh =====
// Assertion macros used by the minimum spanning tree engine top level.
`ifndef MINIMUM_SPANNING_TREE_ENGINE_MACROS_SVH
`define MINIMUM_SPANNING_TREE_ENGINE_MACROS_SVH

// Checked on every clock edge outside reset.
`define MSTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("minimum_spanning_tree_engine: assertion failed");

// Checked on every clock edge, reset included.
`define MSTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("minimum_spanning_tree_engine: assertion failed");

`endif

// ===== sv/mste_pkg.sv =====
// Package with the shared constants, codes and controller types of the engine.
package mste_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VERT_W  = 5;
  localparam int EW_W    = 16;
  localparam int COUNT_W = 6;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } mste_func_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PASS,
    S_SCAN,
    S_PICK,
    S_EMIT
  } mste_state_e;

  typedef struct packed {
    logic clr_wr;
    logic add;
    logic init;
    logic pass_start;
    logic scan;
    logic pick;
    logic emit_start;
    logic emit;
  } mste_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic found;
    logic emit_done;
  } mste_status_t;

endpackage

// ===== sv/minimum_spanning_tree_engine.sv =====
// Top level of the minimum spanning tree engine: controller, datapath and checks.
//
// Requests arrive on start with func, vertex_a, vertex_b and edge_weight and are
// taken at a clock edge where start is high and busy is low. An add-edge request
// writes the pair into the adjacency memory in that cycle, so loads run at one per
// cycle. A clear request sweeps the adjacency memory one entry per cycle.
// A run request performs Prim from vertex 0 over n vertices, where n is vertex_count
// clamped to the range 1 to min(MAX_VERTICES, 32). Each pass makes one scan over the
// row of the chosen vertex through the single read port of the adjacency memory,
// relaxing keys and tracking the next least key at once.
// Results follow for vertices 1 to n-1 in order, one per cycle, each shown for one
// cycle with result_valid_o high; last_o marks the final one. The receiver cannot
// stall, so results are never held back. The vertex count is written through
// vertex_count_we_i and vertex_count_i; the user must write it only while the engine
// is idle, which the block itself does not enforce. Reset sets the vertex count to one
// and starts the clearing sweep; busy stays high until the sweep ends.
`include "minimum_spanning_tree_engine_macros.svh"

module minimum_spanning_tree_engine #(
  parameter int MAX_VERTICES = mste_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mste_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func_i,
  input  logic [mste_pkg::VERT_W-1:0]   vertex_a_i,
  input  logic [mste_pkg::VERT_W-1:0]   vertex_b_i,
  input  logic [mste_pkg::EW_W-1:0]     edge_weight_i,
  input  logic                          vertex_count_we_i,
  input  logic [mste_pkg::COUNT_W-1:0]  vertex_count_i,
  output logic                          result_valid_o,
  output logic [mste_pkg::VERT_W-1:0]   end_low_o,
  output logic [mste_pkg::VERT_W-1:0]   end_high_o,
  output logic [mste_pkg::EW_W-1:0]     tree_weight_o,
  output logic                          unreached_o,
  output logic                          last_o
);

  mste_pkg::mste_cmd_t    cmd;
  mste_pkg::mste_status_t status;

  mste_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  mste_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .vertex_count_we_i (vertex_count_we_i),
    .vertex_count_i    (vertex_count_i),
    .vertex_a_i        (vertex_a_i),
    .vertex_b_i        (vertex_b_i),
    .edge_weight_i     (edge_weight_i),
    .result_valid_o    (result_valid_o),
    .end_low_o         (end_low_o),
    .end_high_o        (end_high_o),
    .tree_weight_o     (tree_weight_o),
    .unreached_o       (unreached_o),
    .last_o            (last_o)
  );

  `MSTE_ASSERT_ALWAYS(a_busy_in_reset, !rst_ni |=> busy)
  `MSTE_ASSERT(a_result_while_busy, result_valid_o |-> busy)
  `MSTE_ASSERT(a_last_ends_run, (result_valid_o && last_o) |=> !result_valid_o)
  `MSTE_ASSERT(a_ends_ordered, result_valid_o |-> (end_low_o < end_high_o))
  `MSTE_ASSERT(a_unreached_zero,
               (result_valid_o && unreached_o) |-> (tree_weight_o == '0 && end_low_o == '0))

endmodule

// ===== sv/mste_ctrl.sv =====
// Controller state machine that sequences clearing, edge loads, Prim passes and output.
module mste_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic [1:0]              func_i,
  input  mste_pkg::mste_status_t  status_i,
  output mste_pkg::mste_cmd_t     cmd_o,
  output logic                    busy
);

  mste_pkg::mste_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mste_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != mste_pkg::S_IDLE);
    case (state_q)
      mste_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_done) begin
          state_d = mste_pkg::S_IDLE;
        end
      end
      mste_pkg::S_IDLE: begin
        if (start) begin
          case (mste_pkg::mste_func_e'(func_i))
            mste_pkg::FUNC_ADD: begin
              cmd_o.add = 1'b1;
            end
            mste_pkg::FUNC_RUN: begin
              cmd_o.init = 1'b1;
              state_d    = mste_pkg::S_PASS;
            end
            mste_pkg::FUNC_CLEAR: begin
              state_d = mste_pkg::S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      mste_pkg::S_PASS: begin
        cmd_o.pass_start = 1'b1;
        state_d          = mste_pkg::S_SCAN;
      end
      mste_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = mste_pkg::S_PICK;
        end
      end
      mste_pkg::S_PICK: begin
        if (status_i.found) begin
          cmd_o.pick = 1'b1;
          state_d    = mste_pkg::S_PASS;
        end else begin
          cmd_o.emit_start = 1'b1;
          state_d          = mste_pkg::S_EMIT;
        end
      end
      mste_pkg::S_EMIT: begin
        if (status_i.emit_done) begin
          state_d = mste_pkg::S_IDLE;
        end else begin
          cmd_o.emit = 1'b1;
        end
      end
      default: begin
        state_d = mste_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/mste_datapath.sv =====
// Datapath with the adjacency memory, per-vertex key arrays, scan counters and result registers.
module mste_datapath #(
  parameter int MAX_VERTICES = mste_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mste_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mste_pkg::mste_cmd_t           cmd_i,
  output mste_pkg::mste_status_t        status_o,
  input  logic                          vertex_count_we_i,
  input  logic [mste_pkg::COUNT_W-1:0]  vertex_count_i,
  input  logic [mste_pkg::VERT_W-1:0]   vertex_a_i,
  input  logic [mste_pkg::VERT_W-1:0]   vertex_b_i,
  input  logic [mste_pkg::EW_W-1:0]     edge_weight_i,
  output logic                          result_valid_o,
  output logic [mste_pkg::VERT_W-1:0]   end_low_o,
  output logic [mste_pkg::VERT_W-1:0]   end_high_o,
  output logic [mste_pkg::EW_W-1:0]     tree_weight_o,
  output logic                          unreached_o,
  output logic                          last_o
);

  localparam int NV        = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int IW        = $clog2(NV);
  localparam int CW        = $clog2(NV + 1);
  localparam int AW        = 2 * IW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int WB        = WEIGHT_BITS;

  logic [WB:0]    mem [MEM_DEPTH];
  logic [WB:0]    rdata_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [WB:0]    mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;

  logic [mste_pkg::COUNT_W-1:0] vc_q;
  logic [CW-1:0]  n_q;
  logic [CW-1:0]  n_clamp;
  logic [CW-1:0]  jr_q;
  logic [CW-1:0]  i_q;
  logic [AW-1:0]  clr_q;
  logic [IW-1:0]  sel_q;
  logic [NV-1:0]  vis_q;
  logic [NV-1:0]  reach_q;
  logic           rd_valid_q;
  logic           found_q;
  logic           res_valid_q;

  logic [WB-1:0]  key_q [NV];
  logic [IW-1:0]  par_q [NV];
  logic [WB-1:0]  best_q;
  logic [IW-1:0]  bidx_q;
  logic [IW-1:0]  jd_q;

  logic [mste_pkg::VERT_W-1:0] a_lo, a_hi;
  logic           add_ok;
  logic [IW-1:0]  jr_idx, r_lo, r_hi;
  logic [IW-1:0]  ridx, i_idx;
  logic [WB-1:0]  w_in, key_r, new_key;
  logic           vis_r, reach_r, upd, new_reach, cand;
  logic [IW-1:0]  p_out, lo_out, hi_out;

  assign a_lo   = (vertex_a_i < vertex_b_i) ? vertex_a_i : vertex_b_i;
  assign a_hi   = (vertex_a_i < vertex_b_i) ? vertex_b_i : vertex_a_i;
  assign add_ok = (int'(a_hi) < NV);

  assign jr_idx = jr_q[IW-1:0];
  assign r_lo   = (sel_q < jr_idx) ? sel_q : jr_idx;
  assign r_hi   = (sel_q < jr_idx) ? jr_idx : sel_q;
  assign mem_re = cmd_i.scan && (jr_q != n_q);
  assign mem_raddr = {r_lo, r_hi};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.add && add_ok) begin
      mem_we    = 1'b1;
      mem_waddr = {IW'(a_lo), IW'(a_hi)};
      mem_wdata = {1'b1, WB'(edge_weight_i)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    if (vc_q == '0) begin
      n_clamp = CW'(1);
    end else if (int'(vc_q) > NV) begin
      n_clamp = CW'(NV);
    end else begin
      n_clamp = CW'(vc_q);
    end
  end

  assign i_idx     = i_q[IW-1:0];
  assign ridx      = cmd_i.emit ? i_idx : jd_q;
  assign vis_r     = vis_q[ridx];
  assign reach_r   = reach_q[ridx];
  assign key_r     = key_q[ridx];
  assign w_in      = rdata_q[WB-1:0];
  assign upd       = !vis_r && rdata_q[WB] && (!reach_r || (key_r > w_in));
  assign new_key   = upd ? w_in : key_r;
  assign new_reach = reach_r || upd;
  assign cand      = !vis_r && new_reach && (!found_q || (new_key < best_q));

  assign p_out  = vis_r ? par_q[ridx] : '0;
  assign lo_out = (p_out < i_idx) ? p_out : i_idx;
  assign hi_out = (p_out < i_idx) ? i_idx : p_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= mste_pkg::COUNT_W'(1);
      n_q         <= CW'(1);
      jr_q        <= '0;
      i_q         <= '0;
      clr_q       <= '0;
      sel_q       <= '0;
      vis_q       <= '0;
      reach_q     <= '0;
      rd_valid_q  <= 1'b0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= mem_re;
      res_valid_q <= cmd_i.emit;
      if (vertex_count_we_i) begin
        vc_q <= vertex_count_i;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.init) begin
        n_q     <= n_clamp;
        sel_q   <= '0;
        vis_q   <= '0;
        reach_q <= NV'(1);
      end
      if (cmd_i.pass_start) begin
        vis_q[sel_q] <= 1'b1;
        jr_q         <= '0;
        found_q      <= 1'b0;
      end
      if (mem_re) begin
        jr_q <= jr_q + CW'(1);
      end
      if (rd_valid_q) begin
        if (upd) begin
          reach_q[jd_q] <= 1'b1;
        end
        if (cand) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.pick) begin
        sel_q <= bidx_q;
      end
      if (cmd_i.emit_start) begin
        i_q <= CW'(1);
      end
      if (cmd_i.emit) begin
        i_q <= i_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    jd_q <= jr_idx;
    if (rd_valid_q) begin
      if (upd) begin
        key_q[jd_q] <= w_in;
        par_q[jd_q] <= sel_q;
      end
      if (cand) begin
        best_q <= new_key;
        bidx_q <= jd_q;
      end
    end
    if (cmd_i.emit) begin
      end_low_o     <= mste_pkg::VERT_W'(lo_out);
      end_high_o    <= mste_pkg::VERT_W'(hi_out);
      tree_weight_o <= vis_r ? mste_pkg::EW_W'(key_r) : '0;
      unreached_o   <= !vis_r;
      last_o        <= (i_q == (n_q - CW'(1)));
    end
  end

  assign result_valid_o     = res_valid_q;
  assign status_o.clr_done  = (clr_q == '1);
  assign status_o.scan_done = (jr_q == n_q) && !rd_valid_q;
  assign status_o.found     = found_q;
  assign status_o.emit_done = (i_q == n_q);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the minimum spanning tree engine, checked against its own Prim predictor.
module testbench;

  typedef struct packed {
    logic [mste_pkg::VERT_W-1:0] lo;
    logic [mste_pkg::VERT_W-1:0] hi;
    logic [mste_pkg::EW_W-1:0]   w;
    logic                        unr;
    logic                        fin;
  } tree_edge_t;

  logic                         clk_i             = 1'b0;
  logic                         rst_ni            = 1'b0;
  logic                         start             = 1'b0;
  logic [1:0]                   func_i            = mste_pkg::FUNC_NOP;
  logic [mste_pkg::VERT_W-1:0]  vertex_a_i        = '0;
  logic [mste_pkg::VERT_W-1:0]  vertex_b_i        = '0;
  logic [mste_pkg::EW_W-1:0]    edge_weight_i     = '0;
  logic                         vertex_count_we_i = 1'b0;
  logic [mste_pkg::COUNT_W-1:0] vertex_count_i    = '0;
  logic                         busy;
  logic                         result_valid_o;
  logic [mste_pkg::VERT_W-1:0]  end_low_o;
  logic [mste_pkg::VERT_W-1:0]  end_high_o;
  logic [mste_pkg::EW_W-1:0]    tree_weight_o;
  logic                         unreached_o;
  logic                         last_o;

  bit                           link_ok [32][32];
  bit [mste_pkg::EW_W-1:0]      link_w  [32][32];
  bit [mste_pkg::COUNT_W-1:0]   count_reg = mste_pkg::COUNT_W'(1);
  tree_edge_t                   tree_expected[$];
  int                           mismatches = 0;
  int                           sent = 0;
  bit                           steady = 1'b0;

  minimum_spanning_tree_engine dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .vertex_a_i        (vertex_a_i),
    .vertex_b_i        (vertex_b_i),
    .edge_weight_i     (edge_weight_i),
    .vertex_count_we_i (vertex_count_we_i),
    .vertex_count_i    (vertex_count_i),
    .result_valid_o    (result_valid_o),
    .end_low_o         (end_low_o),
    .end_high_o        (end_high_o),
    .tree_weight_o     (tree_weight_o),
    .unreached_o       (unreached_o),
    .last_o            (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int active_vertices();
    if (count_reg == 0) return 1;
    if (count_reg > 32) return 32;
    return int'(count_reg);
  endfunction

  function automatic void grow_tree();
    bit                      seen    [32];
    bit                      has_key [32];
    bit [mste_pkg::EW_W-1:0] key     [32];
    int                      parent  [32];
    int                      n;
    int                      sel;
    bit                      found;
    tree_edge_t              e;
    n = active_vertices();
    for (int i = 0; i < 32; i++) begin
      seen[i] = 1'b0;
      has_key[i] = 1'b0;
      key[i] = '0;
      parent[i] = 0;
    end
    has_key[0] = 1'b1;
    for (int pass = 0; pass < n; pass++) begin
      found = 1'b0;
      sel = 0;
      for (int i = 0; i < n; i++) begin
        if (!seen[i] && has_key[i] && (!found || key[i] < key[sel])) begin
          sel = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      seen[sel] = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (!seen[j] && link_ok[sel][j] && (!has_key[j] || key[j] > link_w[sel][j])) begin
          key[j] = link_w[sel][j];
          has_key[j] = 1'b1;
          parent[j] = sel;
        end
      end
    end
    for (int i = 1; i < n; i++) begin
      if (seen[i]) begin
        e.lo = mste_pkg::VERT_W'((parent[i] < i) ? parent[i] : i);
        e.hi = mste_pkg::VERT_W'((parent[i] < i) ? i : parent[i]);
        e.w = key[i];
        e.unr = 1'b0;
      end else begin
        e.lo = '0;
        e.hi = mste_pkg::VERT_W'(i);
        e.w = '0;
        e.unr = 1'b1;
      end
      e.fin = (i == n - 1);
      tree_expected.push_back(e);
    end
  endfunction

  function automatic void apply_request(mste_pkg::mste_func_e f, int a, int b, int w);
    case (f)
      mste_pkg::FUNC_ADD: begin
        link_ok[a][b] = 1'b1;
        link_w[a][b] = w[mste_pkg::EW_W-1:0];
        link_ok[b][a] = 1'b1;
        link_w[b][a] = w[mste_pkg::EW_W-1:0];
      end
      mste_pkg::FUNC_CLEAR: begin
        foreach (link_ok[i, j]) begin
          link_ok[i][j] = 1'b0;
          link_w[i][j] = '0;
        end
      end
      mste_pkg::FUNC_RUN: grow_tree();
      default: ;
    endcase
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16'hFFFF;
      2, 3: return $urandom_range(0, 3);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic send_request(mste_pkg::mste_func_e f, int a = 0, int b = 0, int w = 0);
    if (!steady && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= f;
    vertex_a_i <= a[mste_pkg::VERT_W-1:0];
    vertex_b_i <= b[mste_pkg::VERT_W-1:0];
    edge_weight_i <= w[mste_pkg::EW_W-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_request(f, a % 32, b % 32, w);
    sent++;
  endtask

  task automatic write_count(int value);
    start <= 1'b0;
    while (tree_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    vertex_count_we_i <= 1'b1;
    vertex_count_i <= value[mste_pkg::COUNT_W-1:0];
    @(posedge clk_i);
    vertex_count_we_i <= 1'b0;
    count_reg = value[mste_pkg::COUNT_W-1:0];
  endtask

  task automatic test_single_vertex();
    send_request(mste_pkg::FUNC_RUN);
    send_request(mste_pkg::FUNC_NOP, 31, 31, 16'hFFFF);
    send_request(mste_pkg::FUNC_ADD, 0, 0, 16'h1234);
    send_request(mste_pkg::FUNC_RUN);
    write_count(0);
    send_request(mste_pkg::FUNC_RUN);
  endtask

  task automatic test_overwrite_and_unreached();
    write_count(4);
    send_request(mste_pkg::FUNC_ADD, 0, 1, 16'hFFFF);
    send_request(mste_pkg::FUNC_ADD, 1, 2, 0);
    send_request(mste_pkg::FUNC_ADD, 2, 2, 123);
    send_request(mste_pkg::FUNC_ADD, 1, 0, 7);
    send_request(mste_pkg::FUNC_ADD, 3, 31, 9);
    send_request(mste_pkg::FUNC_ADD, 31, 31, 16'hFFFF);
    send_request(mste_pkg::FUNC_RUN);
    write_count(2);
    send_request(mste_pkg::FUNC_RUN);
    write_count(33);
    send_request(mste_pkg::FUNC_RUN);
  endtask

  task automatic test_tie_break();
    write_count(5);
    send_request(mste_pkg::FUNC_CLEAR);
    send_request(mste_pkg::FUNC_ADD, 0, 2, 5);
    send_request(mste_pkg::FUNC_ADD, 0, 1, 5);
    send_request(mste_pkg::FUNC_ADD, 1, 3, 5);
    send_request(mste_pkg::FUNC_ADD, 2, 3, 5);
    send_request(mste_pkg::FUNC_ADD, 2, 4, 0);
    send_request(mste_pkg::FUNC_RUN);
    send_request(mste_pkg::FUNC_CLEAR);
    send_request(mste_pkg::FUNC_RUN);
  endtask

  task automatic run_random_graph();
    int n;
    int j;
    int extras;
    int reruns;
    case ($urandom_range(0, 9))
      0: write_count(32);
      1: write_count($urandom_range(33, 63));
      2: write_count($urandom_range(0, 1));
      default: write_count($urandom_range(2, 12));
    endcase
    n = active_vertices();
    send_request(mste_pkg::FUNC_CLEAR);
    for (int i = 1; i < n; i++) begin
      if ($urandom_range(0, 11) != 0) begin
        j = $urandom_range(0, i - 1);
        if ($urandom_range(0, 1)) send_request(mste_pkg::FUNC_ADD, i, j, pick_weight());
        else send_request(mste_pkg::FUNC_ADD, j, i, pick_weight());
      end
    end
    reruns = $urandom_range(0, 1);
    for (int r = 0; r <= reruns; r++) begin
      extras = $urandom_range(0, n);
      for (int k = 0; k < extras; k++) begin
        case ($urandom_range(0, 9))
          0: send_request(mste_pkg::FUNC_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                          pick_weight());
          1: send_request(mste_pkg::FUNC_NOP, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 65535));
          2: send_request(mste_pkg::FUNC_RUN);
          default: send_request(mste_pkg::FUNC_ADD, $urandom_range(0, n - 1),
                                $urandom_range(0, n - 1), pick_weight());
        endcase
      end
      send_request(mste_pkg::FUNC_RUN);
    end
  endtask

  task automatic test_random_graphs();
    while (sent < 400) run_random_graph();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    while (sent < 470) run_random_graph();
  endtask

  always @(posedge clk_i) begin : check_result
    tree_edge_t want;
    if (rst_ni && result_valid_o) begin
      if (tree_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: lo %0d hi %0d w %0d unr %0b last %0b",
                   end_low_o, end_high_o, tree_weight_o, unreached_o, last_o);
      end else begin
        want = tree_expected.pop_front();
        if (end_low_o !== want.lo || end_high_o !== want.hi || tree_weight_o !== want.w ||
            unreached_o !== want.unr || last_o !== want.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected lo %0d hi %0d w %0d unr %0b last %0b,",
                      " got lo %0d hi %0d w %0d unr %0b last %0b"},
                     want.lo, want.hi, want.w, want.unr, want.fin,
                     end_low_o, end_high_o, tree_weight_o, unreached_o, last_o);
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_vertex();
    test_overwrite_and_unreached();
    test_tie_break();
    test_random_graphs();
    test_back_to_back();
    start <= 1'b0;
    while (tree_expected.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && tree_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
